// ===== rtl/output_channel_panel_controller_top_assert.svh =====
// Assertion macros used by the panel controller RTL.
`ifndef OUTPUT_CHANNEL_PANEL_CONTROLLER_TOP_ASSERT_SVH
`define OUTPUT_CHANNEL_PANEL_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define OCPC_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ocpc same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define OCPC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ocpc next-cycle check failed");

`else

`define OCPC_ASSERT_SAME(label, clk, rst, cond, expr)
`define OCPC_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== rtl/ocpc_pkg.sv =====
// Types and constants of the output channel panel controller.
package ocpc_pkg;

   localparam int unsigned CHANNELS = 16;
   localparam int unsigned CHAN_IDX_W = 4;

   // Action codes of an input item.
   localparam logic [1:0] ACTION_TICK   = 2'd0;
   localparam logic [1:0] ACTION_SWITCH = 2'd1;
   localparam logic [1:0] ACTION_STATUS = 2'd2;

   // Switch command codes.
   localparam logic [7:0] CMD_ON  = 8'h01;
   localparam logic [7:0] CMD_OFF = 8'h02;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATION      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MENU_TIMEOUT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_SHORT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_LONG   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKOUT      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_DIV     = 3'd5;

   // Configuration reset values.
   localparam logic [5:0]  RST_STATION      = 6'd0;
   localparam logic [15:0] RST_MENU_TIMEOUT = 16'd10000;
   localparam logic [9:0]  RST_BLINK_SHORT  = 10'd50;
   localparam logic [11:0] RST_BLINK_LONG   = 12'd250;
   localparam logic [7:0]  RST_LOCKOUT      = 8'd200;
   localparam logic [7:0]  RST_SCAN_DIV     = 8'd5;

   localparam logic [11:0] BLINK_ELAPSED_MAX = 12'hFFF;
   localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL = 4'd15;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] bus_address;
      logic [7:0]  command_code;
      logic        select_pressed;
      logic        onoff_pressed;
   } ocpc_req_type;

   typedef struct packed {
      logic [15:0] gate_drive;
      logic [3:0]  row_drive;
      logic [3:0]  column_drive;
      logic        reply_valid;
      logic        reply_on;
   } ocpc_rsp_type;

endpackage

// ===== rtl/ocpc_chan_if.sv =====
// Valid/ready channel interface carrying one payload item per transfer.
interface ocpc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/output_channel_panel_controller_top.sv =====
// Sixteen-channel gate controller with bus commands, panel menu and matrix scan.
//
// The req_chan sink takes one item per transfer: a one millisecond tick that
// carries the two button levels, a switch command or a status query. Each
// accepted item gives exactly one item on the rsp_chan source: the gate
// outputs, the indicator matrix row and columns, and the bus reply flags.
// The whole state update is combinational from the accepted item into the state
// flops and the result register, so a result is offered in the cycle after its
// item's transfer; one item per cycle is sustained while results are taken. The
// result register is the only buffer: while a result waits, a new item is still
// taken in the same cycle the waiting result transfers. When the receiver stalls,
// req_chan.ready drops until the result is taken. Configuration is written over
// the csr_ port, one register per cycle; the user must write only while idle, not
// enforced by the block. Synchronous reset clears all gates, closes the menu,
// restores the register defaults and empties the result register.
`include "output_channel_panel_controller_top_assert.svh"

module output_channel_panel_controller_top
   import ocpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ocpc_chan_if.sink              req_chan,
   ocpc_chan_if.source            rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Configuration registers.
   logic [5:0]  station_ff;
   logic [15:0] menu_timeout_ff;
   logic [9:0]  blink_short_ff;
   logic [11:0] blink_long_ff;
   logic [7:0]  lockout_ticks_ff;
   logic [7:0]  scan_div_ff;

   // Block state.
   logic [CHANNELS-1:0]   channel_on_ff, channel_on_in;
   logic [CHANNELS-1:0]   indicator_on_ff, indicator_on_in;
   logic [CHAN_IDX_W-1:0] selected_ff, selected_in;
   logic                  menu_open_ff, menu_open_in;
   logic [15:0]           countdown_ff, countdown_in;
   logic                  blink_phase_ff, blink_phase_in;
   logic [11:0]           blink_elapsed_ff, blink_elapsed_in;
   logic                  blink_restart_ff, blink_restart_in;
   logic                  select_held_ff, select_held_in;
   logic                  onoff_held_ff, onoff_held_in;
   logic [7:0]            lockout_ff, lockout_in;
   logic [1:0]            scan_row_ff, scan_row_in;
   logic [7:0]            scan_prescale_ff, scan_prescale_in;

   // Result register.
   logic         rsp_valid_ff;
   ocpc_rsp_type rsp_payload_ff, rsp_payload_in;

   logic         req_transfer;
   ocpc_req_type req;

   assign req               = req_chan.payload;
   assign req_chan.ready    = !rsp_valid_ff || rsp_chan.ready;
   assign req_transfer      = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.payload  = rsp_payload_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff       <= RST_STATION;
         menu_timeout_ff  <= RST_MENU_TIMEOUT;
         blink_short_ff   <= RST_BLINK_SHORT;
         blink_long_ff    <= RST_BLINK_LONG;
         lockout_ticks_ff <= RST_LOCKOUT;
         scan_div_ff      <= RST_SCAN_DIV;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STATION:      station_ff       <= csr_write_data[5:0];
            CSR_MENU_TIMEOUT: menu_timeout_ff  <= csr_write_data;
            CSR_BLINK_SHORT:  blink_short_ff   <= csr_write_data[9:0];
            CSR_BLINK_LONG:   blink_long_ff    <= csr_write_data[11:0];
            CSR_LOCKOUT:      lockout_ticks_ff <= csr_write_data[7:0];
            CSR_SCAN_DIV:     scan_div_ff      <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Next state and result for the item on the request channel.
   always_comb begin
      logic                  edge_seen;
      logic [11:0]           short_len;
      logic [11:0]           long_len;
      logic [11:0]           period;
      logic [7:0]            div;
      logic                  sel_state;
      logic [15:0]           window_start;
      logic [16:0]           offset;
      logic                  hit;
      logic [CHAN_IDX_W-1:0] idx;
      logic [3:0]            cols;

      channel_on_in    = channel_on_ff;
      indicator_on_in  = indicator_on_ff;
      selected_in      = selected_ff;
      menu_open_in     = menu_open_ff;
      countdown_in     = countdown_ff;
      blink_phase_in   = blink_phase_ff;
      blink_elapsed_in = blink_elapsed_ff;
      blink_restart_in = blink_restart_ff;
      select_held_in   = select_held_ff;
      onoff_held_in    = onoff_held_ff;
      lockout_in       = lockout_ff;
      scan_row_in      = scan_row_ff;
      scan_prescale_in = scan_prescale_ff;
      edge_seen        = 1'b0;
      period           = '0;
      sel_state        = 1'b0;
      hit              = 1'b0;
      idx              = '0;
      short_len = (blink_short_ff == '0) ? 12'd1 : {2'b00, blink_short_ff};
      long_len  = (blink_long_ff == '0) ? 12'd1 : blink_long_ff;
      div       = (scan_div_ff == '0) ? 8'd1 : scan_div_ff;

      // Bus window: station zero answers address zero only.
      window_start = (station_ff == '0) ? 16'd0
                   : 16'({station_ff - 6'd1, 4'b0000}) + 16'd1;
      offset = {1'b0, req.bus_address} - {1'b0, window_start};

      case (req.action)
         ACTION_TICK: begin
            // Buttons, or lockout countdown.
            if (lockout_in != '0) begin
               lockout_in = lockout_in - 8'd1;
            end else begin
               if (req.select_pressed) begin
                  if (!select_held_in) begin
                     select_held_in   = 1'b1;
                     menu_open_in     = 1'b1;
                     blink_restart_in = 1'b1;
                     selected_in      = selected_in + 4'd1;
                     blink_phase_in   = channel_on_in[selected_in];
                     countdown_in     = menu_timeout_ff;
                     indicator_on_in  = channel_on_in;
                     edge_seen        = 1'b1;
                  end
               end else if (select_held_in) begin
                  select_held_in  = 1'b0;
                  indicator_on_in = channel_on_in;
                  edge_seen       = 1'b1;
               end
               if (menu_open_in && req.onoff_pressed) begin
                  if (!onoff_held_in) begin
                     onoff_held_in = 1'b1;
                     channel_on_in[selected_in] = !channel_on_in[selected_in];
                     blink_restart_in = 1'b1;
                     blink_phase_in   = channel_on_in[selected_in];
                     indicator_on_in  = channel_on_in;
                     edge_seen        = 1'b1;
                  end
                  countdown_in = menu_timeout_ff;
               end else if (!req.onoff_pressed && onoff_held_in) begin
                  onoff_held_in = 1'b0;
                  edge_seen     = 1'b1;
               end
               if (edge_seen) begin
                  lockout_in = lockout_ticks_ff;
               end
            end

            // Menu timeout; a closed menu shows the plain channel state.
            if (!menu_open_in || countdown_in == '0) begin
               menu_open_in     = 1'b0;
               selected_in      = LAST_CHANNEL;
               blink_phase_in   = 1'b0;
               blink_restart_in = 1'b1;
               indicator_on_in  = channel_on_in;
            end else begin
               countdown_in = countdown_in - 16'd1;
            end

            // Blink of the selected indicator.
            sel_state = channel_on_in[selected_in];
            if (blink_restart_in) begin
               blink_phase_in   = sel_state;
               blink_elapsed_in = '0;
               blink_restart_in = 1'b0;
            end else if (blink_elapsed_in < BLINK_ELAPSED_MAX) begin
               blink_elapsed_in = blink_elapsed_in + 12'd1;
            end
            if (sel_state) begin
               period = blink_phase_in ? long_len : short_len;
            end else begin
               period = blink_phase_in ? short_len : long_len;
            end
            if (blink_elapsed_in >= period) begin
               indicator_on_in[selected_in] = !indicator_on_in[selected_in];
               blink_phase_in   = !blink_phase_in;
               blink_elapsed_in = '0;
            end

            // Matrix row step.
            scan_prescale_in = scan_prescale_ff + 8'd1;
            if (scan_prescale_in >= div) begin
               scan_prescale_in = '0;
               scan_row_in      = scan_row_ff + 2'd1;
            end
         end
         ACTION_SWITCH, ACTION_STATUS: begin
            if (station_ff == '0) begin
               hit = (req.bus_address == '0);
            end else begin
               hit = (req.bus_address >= window_start) && (offset < 17'd16);
            end
            idx = offset[CHAN_IDX_W-1:0];
            if (hit && req.action == ACTION_SWITCH) begin
               if (req.command_code == CMD_ON) begin
                  channel_on_in[idx] = 1'b1;
               end else if (req.command_code == CMD_OFF) begin
                  channel_on_in[idx] = 1'b0;
               end
               indicator_on_in = channel_on_in;
            end
         end
         default: ;
      endcase

      // Columns are active low for the row being driven.
      for (int c = 0; c < 4; c++) begin
         cols[c] = !indicator_on_in[{c[1:0], scan_row_in}];
      end

      rsp_payload_in.gate_drive   = channel_on_in;
      rsp_payload_in.row_drive    = 4'(4'b0001 << scan_row_in);
      rsp_payload_in.column_drive = cols;
      rsp_payload_in.reply_valid  = hit;
      rsp_payload_in.reply_on     = hit && channel_on_in[idx];
   end

   // State update on each input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_on_ff    <= '0;
         indicator_on_ff  <= '0;
         selected_ff      <= LAST_CHANNEL;
         menu_open_ff     <= 1'b0;
         countdown_ff     <= '0;
         blink_phase_ff   <= 1'b0;
         blink_elapsed_ff <= '0;
         blink_restart_ff <= 1'b1;
         select_held_ff   <= 1'b0;
         onoff_held_ff    <= 1'b0;
         lockout_ff       <= '0;
         scan_row_ff      <= '0;
         scan_prescale_ff <= '0;
      end else if (req_transfer) begin
         channel_on_ff    <= channel_on_in;
         indicator_on_ff  <= indicator_on_in;
         selected_ff      <= selected_in;
         menu_open_ff     <= menu_open_in;
         countdown_ff     <= countdown_in;
         blink_phase_ff   <= blink_phase_in;
         blink_elapsed_ff <= blink_elapsed_in;
         blink_restart_ff <= blink_restart_in;
         select_held_ff   <= select_held_in;
         onoff_held_ff    <= onoff_held_in;
         lockout_ff       <= lockout_in;
         scan_row_ff      <= scan_row_in;
         scan_prescale_ff <= scan_prescale_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_transfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload, loaded with each input transfer.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // A closed menu always points at the last channel.
   `OCPC_ASSERT_SAME(a_closed_menu_sel, clock, reset, !menu_open_ff,
                     selected_ff == LAST_CHANNEL)

   // A reply state is only given with a valid reply.
   `OCPC_ASSERT_SAME(a_reply_on_valid, clock, reset,
                     rsp_valid_ff && !rsp_payload_ff.reply_valid,
                     !rsp_payload_ff.reply_on)

   // The driven row is always exactly one.
   `OCPC_ASSERT_SAME(a_row_onehot, clock, reset, rsp_valid_ff,
                     $onehot(rsp_payload_ff.row_drive))

   // Bus commands do not advance the matrix scan.
   `OCPC_ASSERT_NEXT(a_bus_no_scan, clock, reset,
                     req_transfer && req.action != ACTION_TICK,
                     $stable(scan_row_ff) && $stable(scan_prescale_ff))

endmodule

// ===== bench/panel_checker.sv =====
// Checker for the panel controller: predicts every result and compares it with the DUT.
`timescale 1ns / 1ps

module panel_checker
   import ocpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  ocpc_req_type           req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ocpc_rsp_type           rsp_item,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int unsigned            mismatch_count,
   output int unsigned            results_owed
);

   // Register copies, kept at the widths of the block.
   logic [5:0]  station_cfg;
   logic [15:0] timeout_cfg;
   logic [9:0]  short_cfg;
   logic [11:0] long_cfg;
   logic [7:0]  lockout_cfg;
   logic [7:0]  scan_div_cfg;

   // Predicted controller state.
   logic [15:0] channel_on;
   logic [15:0] indicator_on;
   logic [3:0]  menu_pick;
   logic        menu_open;
   logic [15:0] menu_countdown;
   logic        blink_phase;
   logic [11:0] blink_elapsed;
   logic        blink_restart;
   logic        select_held;
   logic        onoff_held;
   logic [7:0]  lockout_count;
   logic [1:0]  scan_row;
   logic [7:0]  scan_prescale;

   ocpc_rsp_type owed_results[$];
   int unsigned  errors = 0;

   assign mismatch_count = errors;

   // Applies one accepted item to the predicted state and returns the outputs it yields.
   function automatic ocpc_rsp_type advance_controller(ocpc_req_type item);
      ocpc_rsp_type result;
      logic         pressed_edge;
      logic [16:0]  win_lo;
      logic [16:0]  win_hi;
      logic [16:0]  addr;
      logic [3:0]   idx;
      logic [11:0]  short_len;
      logic [11:0]  long_len;
      logic [11:0]  period;
      logic [8:0]   divider;
      logic [8:0]   next_prescale;

      result = '0;
      if (item.action == ACTION_TICK) begin
         // Buttons are ignored while the lockout runs down.
         if (lockout_count != 0) begin
            lockout_count = lockout_count - 8'd1;
         end else begin
            pressed_edge = 1'b0;
            if (item.select_pressed) begin
               if (!select_held) begin
                  select_held = 1'b1;
                  menu_open = 1'b1;
                  blink_restart = 1'b1;
                  menu_pick = menu_pick + 4'd1;
                  blink_phase = channel_on[menu_pick];
                  menu_countdown = timeout_cfg;
                  indicator_on = channel_on;
                  pressed_edge = 1'b1;
               end
            end else if (select_held) begin
               select_held = 1'b0;
               indicator_on = channel_on;
               pressed_edge = 1'b1;
            end
            if (menu_open && item.onoff_pressed) begin
               if (!onoff_held) begin
                  onoff_held = 1'b1;
                  channel_on[menu_pick] = ~channel_on[menu_pick];
                  blink_restart = 1'b1;
                  blink_phase = channel_on[menu_pick];
                  indicator_on = channel_on;
                  pressed_edge = 1'b1;
               end
               menu_countdown = timeout_cfg;
            end else if (!item.onoff_pressed && onoff_held) begin
               onoff_held = 1'b0;
               pressed_edge = 1'b1;
            end
            if (pressed_edge)
               lockout_count = lockout_cfg;
         end

         // A closed or expired menu falls back to the idle display every tick.
         if (!menu_open || menu_countdown == 0) begin
            menu_open = 1'b0;
            menu_pick = LAST_CHANNEL;
            blink_phase = 1'b0;
            blink_restart = 1'b1;
            indicator_on = channel_on;
         end else begin
            menu_countdown = menu_countdown - 16'd1;
         end

         // Unequal blink: long phase matches the channel state.
         short_len = (short_cfg != 0) ? {2'b00, short_cfg} : 12'd1;
         long_len = (long_cfg != 0) ? long_cfg : 12'd1;
         if (blink_restart) begin
            blink_phase = channel_on[menu_pick];
            blink_elapsed = '0;
            blink_restart = 1'b0;
         end else if (blink_elapsed < BLINK_ELAPSED_MAX) begin
            blink_elapsed = blink_elapsed + 12'd1;
         end
         if (channel_on[menu_pick])
            period = blink_phase ? long_len : short_len;
         else
            period = blink_phase ? short_len : long_len;
         if (blink_elapsed >= period) begin
            indicator_on[menu_pick] = ~indicator_on[menu_pick];
            blink_phase = ~blink_phase;
            blink_elapsed = '0;
         end

         // Matrix row stepping.
         divider = (scan_div_cfg != 0) ? {1'b0, scan_div_cfg} : 9'd1;
         next_prescale = {1'b0, scan_prescale} + 9'd1;
         if (next_prescale >= divider) begin
            scan_prescale = '0;
            scan_row = scan_row + 2'd1;
         end else begin
            scan_prescale = next_prescale[7:0];
         end
      end else if (item.action == ACTION_SWITCH || item.action == ACTION_STATUS) begin
         // Station zero answers on address zero alone.
         if (station_cfg != 0) begin
            win_lo = 17'((int'(station_cfg) - 1) * CHANNELS + 1);
            win_hi = win_lo + 17'd15;
         end else begin
            win_lo = '0;
            win_hi = '0;
         end
         addr = {1'b0, item.bus_address};
         if (addr >= win_lo && addr <= win_hi) begin
            idx = 4'(addr - win_lo);
            if (item.action == ACTION_SWITCH) begin
               if (item.command_code == CMD_ON)
                  channel_on[idx] = 1'b1;
               else if (item.command_code == CMD_OFF)
                  channel_on[idx] = 1'b0;
               indicator_on = channel_on;
            end
            result.reply_valid = 1'b1;
            result.reply_on = channel_on[idx];
         end
      end

      result.gate_drive = channel_on;
      result.row_drive = 4'b0001 << scan_row;
      for (int c = 0; c < 4; c++)
         result.column_drive[c] = ~indicator_on[c * 4 + scan_row];
      return result;
   endfunction

   function automatic void compare_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endfunction

   // Track configuration, check result transfers, then queue predictions for input transfers.
   always @(posedge clock) begin
      ocpc_rsp_type want;
      if (reset) begin
         station_cfg = RST_STATION;
         timeout_cfg = RST_MENU_TIMEOUT;
         short_cfg = RST_BLINK_SHORT;
         long_cfg = RST_BLINK_LONG;
         lockout_cfg = RST_LOCKOUT;
         scan_div_cfg = RST_SCAN_DIV;
         channel_on = '0;
         indicator_on = '0;
         menu_pick = LAST_CHANNEL;
         menu_open = 1'b0;
         menu_countdown = '0;
         blink_phase = 1'b0;
         blink_elapsed = '0;
         blink_restart = 1'b1;
         select_held = 1'b0;
         onoff_held = 1'b0;
         lockout_count = '0;
         scan_row = '0;
         scan_prescale = '0;
         owed_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STATION:      station_cfg = csr_write_data[5:0];
               CSR_MENU_TIMEOUT: timeout_cfg = csr_write_data;
               CSR_BLINK_SHORT:  short_cfg = csr_write_data[9:0];
               CSR_BLINK_LONG:   long_cfg = csr_write_data[11:0];
               CSR_LOCKOUT:      lockout_cfg = csr_write_data[7:0];
               CSR_SCAN_DIV:     scan_div_cfg = csr_write_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               errors++;
               $display("%0t ns: result transfer with none expected, actual %h",
                        $time, rsp_item);
            end else begin
               want = owed_results.pop_front();
               compare_field("gate_drive", want.gate_drive, rsp_item.gate_drive);
               compare_field("row_drive", 16'(want.row_drive), 16'(rsp_item.row_drive));
               compare_field("column_drive", 16'(want.column_drive),
                             16'(rsp_item.column_drive));
               compare_field("reply_valid", 16'(want.reply_valid),
                             16'(rsp_item.reply_valid));
               compare_field("reply_on", 16'(want.reply_on), 16'(rsp_item.reply_on));
            end
         end
         if (req_valid && req_ready)
            owed_results.push_back(advance_controller(req_item));
      end
      results_owed <= owed_results.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the panel controller testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
   import ocpc_pkg::*;

   localparam logic [1:0]  ACTION_UNUSED   = 2'd3;
   localparam int          PHASES          = 12;
   localparam int          ITEMS_PER_PHASE = 160;
   localparam int unsigned CYCLE_LIMIT     = 600000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   logic        idling_on;
   logic        select_level = 1'b0;
   logic        onoff_level = 1'b0;
   int          window_lo = 0;
   int          window_hi = 0;

   ocpc_chan_if #(.payload_type(ocpc_req_type)) req_chan ();
   ocpc_chan_if #(.payload_type(ocpc_rsp_type)) rsp_chan ();

   output_channel_panel_controller_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   panel_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_item         (req_chan.payload),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_item         (rsp_chan.payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .results_owed     (results_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result receiver: random stall bursts while idling is on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Offers one item, with an occasional gap first, and returns at its transfer.
   task automatic send_item(input ocpc_req_type item);
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_tick(input logic sel, input logic onoff);
      ocpc_req_type item;
      item = '0;
      item.action = ACTION_TICK;
      item.select_pressed = sel;
      item.onoff_pressed = onoff;
      send_item(item);
   endtask

   task automatic send_bus(input logic [1:0] action, input logic [15:0] addr,
                           input logic [7:0] code);
      ocpc_req_type item;
      item = '0;
      item.action = action;
      item.bus_address = addr;
      item.command_code = code;
      send_item(item);
   endtask

   // Stops offering and waits until every result has been taken.
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic program_settings(input int station, input int timeout, input int short_len,
                                   input int long_len, input int lockout, input int divider);
      write_register(CSR_STATION, station);
      write_register(CSR_MENU_TIMEOUT, timeout);
      write_register(CSR_BLINK_SHORT, short_len);
      write_register(CSR_BLINK_LONG, long_len);
      write_register(CSR_LOCKOUT, lockout);
      write_register(CSR_SCAN_DIV, divider);
      csr_write_enable <= 1'b0;
      window_lo = (station == 0) ? 0 : (station - 1) * 16 + 1;
      window_hi = (station == 0) ? 0 : window_lo + 15;
   endtask

   // Mostly ticks with buttons held for random stretches, plus bus traffic around the window.
   function automatic ocpc_req_type random_item();
      ocpc_req_type item;
      int           pick;
      item.bus_address = 16'($urandom);
      item.command_code = 8'($urandom);
      item.select_pressed = 1'($urandom);
      item.onoff_pressed = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 60) item.action = ACTION_TICK;
      else if (pick < 80) item.action = ACTION_SWITCH;
      else if (pick < 95) item.action = ACTION_STATUS;
      else item.action = ACTION_UNUSED;

      if (item.action == ACTION_TICK) begin
         if ($urandom_range(0, 3) == 0) select_level = ~select_level;
         if ($urandom_range(0, 3) == 0) onoff_level = ~onoff_level;
         item.select_pressed = select_level;
         item.onoff_pressed = onoff_level;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            item.bus_address = 16'(window_lo + $urandom_range(0, window_hi - window_lo));
         else if (pick < 80)
            item.bus_address = (window_lo == 0) ? 16'(window_hi + 1) : 16'(window_lo - 1);
         else if (pick < 85)
            item.bus_address = 16'(window_hi + 1);
         pick = $urandom_range(0, 99);
         if (pick < 40) item.command_code = CMD_ON;
         else if (pick < 80) item.command_code = CMD_OFF;
      end
      return item;
   endfunction

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      idling_on <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Station zero window at reset values: only address zero answers.
      send_bus(ACTION_STATUS, 16'd0, 8'h00);
      send_bus(ACTION_SWITCH, 16'd0, CMD_ON);
      send_bus(ACTION_STATUS, 16'd0, 8'h00);
      send_bus(ACTION_SWITCH, 16'd1, CMD_ON);
      send_bus(ACTION_SWITCH, 16'hFFFF, 8'hFF);
      send_bus(ACTION_SWITCH, 16'd0, 8'hFF);
      send_bus(ACTION_UNUSED, 16'd0, CMD_OFF);
      send_bus(ACTION_SWITCH, 16'd0, CMD_OFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_drained();
         idling_on <= (phase == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         case (phase)
            0: program_settings(63, 1, 1, 1, 0, 1);
            1: program_settings(1, 65535, 1023, 4095, 255, 255);
            // Zero blink and scan lengths behave as one.
            2: program_settings($urandom_range(0, 63), 7, 0, 0, 0, 0);
            default:
               program_settings($urandom_range(0, 63),
                                $urandom_range(0, 1) ? $urandom_range(1, 40)
                                                     : $urandom_range(1, 400),
                                $urandom_range(1, 8), $urandom_range(1, 12),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 3),
                                $urandom_range(1, 4));
         endcase

         if (phase == 0) begin
            // Menu walk with no lockout, then the edges of the top station window.
            send_tick(1'b1, 1'b0);
            send_tick(1'b1, 1'b1);
            send_tick(1'b0, 1'b1);
            send_tick(1'b1, 1'b0);
            send_tick(1'b1, 1'b1);
            send_tick(1'b0, 1'b0);
            send_tick(1'b0, 1'b0);
            send_bus(ACTION_SWITCH, 16'd992, CMD_ON);
            send_bus(ACTION_SWITCH, 16'd993, CMD_ON);
            send_bus(ACTION_SWITCH, 16'd1008, CMD_ON);
            send_bus(ACTION_SWITCH, 16'd1009, CMD_ON);
            send_bus(ACTION_STATUS, 16'd1008, 8'h00);
            send_bus(ACTION_STATUS, 16'hFFFF, 8'h00);
         end

         repeat (ITEMS_PER_PHASE) send_item(random_item());
      end

      wait_until_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ocpc_pkg.sv
rtl/ocpc_chan_if.sv
rtl/output_channel_panel_controller_top.sv
bench/panel_checker.sv
bench/testbench.sv
